@@ design/wcts_pkg.sv @@
// Package for the wall column texture scaler.
// Holds payload structs, the front-to-back command struct and shared constants.
// No dependencies.
package wcts_pkg;

	localparam int ScreenRows   = 64;
	localparam int TexSize      = 64;
	localparam int TextureCount = 8;
	localparam int StoreDepth   = 32768;
	localparam int AddrW        = 15;
	localparam logic [15:0] FadeReset = 16'd2048;
	localparam logic [8:0]  FadeFull  = 9'd256;

	localparam logic FUNC_WRITE = 1'b0;
	localparam logic FUNC_DRAW  = 1'b1;

	typedef struct packed {
		logic        func;
		logic [14:0] texel_index;
		logic [23:0] texel_rgb;
		logic [6:0]  column_x;
		logic [15:0] wall_height;
		logic [15:0] texture_u;
		logic [15:0] distance;
		logic [1:0]  wall_kind;
		logic        side_west_east;
	} in_item_t;

	typedef struct packed {
		logic [6:0]  out_column;
		logic [5:0]  out_row;
		logic [23:0] pixel_rgb;
		logic        last_pixel;
	} out_item_t;

	// One column job handed from the front part to the back part.
	typedef struct packed {
		logic [6:0]  column;
		logic [15:0] height;
		logic        clipped;
		logic [5:0]  start_row;
		logic [6:0]  count;
		logic [2:0]  tex;
		logic [5:0]  src_col;
		logic [8:0]  fade;
	} col_job_t;

endpackage

@@ design/wcts_ram.sv @@
// Generic single-port write, single-port read RAM with registered read.
// No dependencies.
module wcts_ram #(
	parameter int Width = 24,
	parameter int Depth = 32768,
	parameter int AddrBits = $clog2(Depth)
) (
	input  logic                clk,
	input  logic                we,
	input  logic [AddrBits-1:0] waddr,
	input  logic [Width-1:0]    wdata,
	input  logic                re,
	input  logic [AddrBits-1:0] raddr,
	output logic [Width-1:0]    rdata
);
	logic [Width-1:0] mem_q [Depth];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

@@ design/wcts_front.sv @@
// Front part: accepts items, writes texels, classifies draws and computes fade.
// Depends on wcts_pkg; fade uses a restoring divider, one quotient bit a cycle.
module wcts_front
	import wcts_pkg::*;
(
	input  logic           clk,
	input  logic           arst_n,
	input  logic [15:0]    fade_distance,
	input  logic           draw_pending,
	input  in_item_t       in_item,
	input  logic           in_valid,
	output logic           in_ready,
	output logic           tex_we,
	output logic [14:0]    tex_waddr,
	output logic [23:0]    tex_wdata,
	output col_job_t       job,
	output logic           job_valid,
	input  logic           job_ready
);
	typedef enum logic [2:0] {
		F_IDLE = 3'b001,
		F_DIV  = 3'b010,
		F_PUSH = 3'b100
	} fstate_t;

	fstate_t     state_q;
	col_job_t    job_q;
	logic [24:0] rem_q;
	logic [15:0] div_q;
	logic [23:0] num_q;
	logic [24:0] quo_q;
	logic [4:0]  cnt_q;
	logic [25:0] rem_shift;
	logic [24:0] quo_next;
	logic        accept;
	logic [6:0]  col_c;
	logic [2:0]  tex_c;

	// A texel write waits until every earlier draw has finished reading the store.
	assign in_ready  = (state_q == F_IDLE) && !(draw_pending && in_item.func == FUNC_WRITE);
	assign accept    = in_valid && in_ready;
	assign tex_we    = accept && (in_item.func == FUNC_WRITE);
	assign tex_waddr = in_item.texel_index;
	assign tex_wdata = in_item.texel_rgb;
	assign job       = job_q;
	assign job_valid = (state_q == F_PUSH);
	assign rem_shift = {rem_q, num_q[23]};
	assign quo_next  = {quo_q[23:0], rem_shift >= {10'd0, div_q}};
	assign col_c     = (in_item.wall_height > 16'(ScreenRows)) ? 7'(ScreenRows)
	                 : in_item.wall_height[6:0];
	assign tex_c     = 3'({1'b0, in_item.wall_kind}
	                 + (in_item.side_west_east ? 3'(TextureCount / 2) : 3'd0));

	// Control and the fade division, fade_distance*256 / distance.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
		end else begin
			case (state_q)
				F_IDLE: begin
					if (accept && in_item.func == FUNC_DRAW && in_item.wall_height != 16'd0) begin
						state_q <= (in_item.distance == 16'd0) ? F_PUSH : F_DIV;
					end
				end
				F_DIV: begin
					if (cnt_q == 5'd23) begin
						state_q <= F_PUSH;
					end
				end
				F_PUSH: begin
					if (job_ready) begin
						state_q <= F_IDLE;
					end
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

	// Job fields and divider datapath. The saturated fade is stored with the last
	// quotient bit, so the job is complete when it is offered.
	always_ff @(posedge clk) begin
		if (accept) begin
			job_q.column    <= in_item.column_x;
			job_q.height    <= in_item.wall_height;
			job_q.clipped   <= in_item.wall_height > 16'(ScreenRows);
			job_q.count     <= col_c;
			job_q.start_row <= 6'((7'(ScreenRows) - col_c) >> 1);
			job_q.tex       <= tex_c;
			job_q.src_col   <= in_item.texture_u[15:10];
			job_q.fade      <= FadeFull;
			rem_q           <= '0;
			div_q           <= in_item.distance;
			num_q           <= {fade_distance, 8'd0};
			quo_q           <= '0;
			cnt_q           <= '0;
		end else if (state_q == F_DIV) begin
			if (rem_shift >= {10'd0, div_q}) begin
				rem_q <= 25'(rem_shift - {10'd0, div_q});
			end else begin
				rem_q <= rem_shift[24:0];
			end
			quo_q <= quo_next;
			num_q <= {num_q[22:0], 1'b0};
			cnt_q <= cnt_q + 5'd1;
			if (cnt_q == 5'd23) begin
				job_q.fade <= (quo_next > 25'(FadeFull)) ? FadeFull : quo_next[8:0];
			end
		end
	end
endmodule

@@ design/wcts_queue.sv @@
// Two-entry job queue between the front and back parts.
// Depends on wcts_pkg.
module wcts_queue
	import wcts_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  col_job_t wr_job,
	input  logic     wr_valid,
	output logic     wr_ready,
	output col_job_t rd_job,
	output logic     rd_valid,
	input  logic     rd_ready
);
	col_job_t   slot_q [2];
	logic       wptr_q;
	logic       rptr_q;
	logic [1:0] fill_q;
	logic       push;
	logic       pop;

	assign wr_ready = (fill_q != 2'd2);
	assign rd_valid = (fill_q != 2'd0);
	assign rd_job   = slot_q[rptr_q];
	assign push     = wr_valid && wr_ready;
	assign pop      = rd_valid && rd_ready;

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			fill_q <= 2'd0;
		end else begin
			if (push) wptr_q <= ~wptr_q;
			if (pop)  rptr_q <= ~rptr_q;
			fill_q <= 2'(fill_q + {1'b0, push} - {1'b0, pop});
		end
	end

	// Storage.
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wptr_q] <= wr_job;
		end
	end
endmodule

@@ design/wcts_back.sv @@
// Back part: walks the visible rows of a column, reads texels and fades them.
// Depends on wcts_pkg; texture rows come from an exact rational accumulator.
module wcts_back
	import wcts_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  col_job_t    job,
	input  logic        job_valid,
	output logic        job_ready,
	output logic        tex_re,
	output logic [14:0] tex_raddr,
	input  logic [23:0] tex_rdata,
	output out_item_t   out_item,
	output logic        out_valid,
	input  logic        out_ready
);
	// Row walk registers. src_row advances by step_q / den_q with remainder kept.
	logic        busy_q;
	col_job_t    cur_q;
	logic [6:0]  idx_q;
	logic [5:0]  srow_q;
	logic [21:0] acc_q;
	logic [17:0] den_q;
	logic [7:0]  step_q;
	logic [21:0] acc_next;
	logic [5:0]  srow_next;

	// Stage 1: memory read issued; stage 2: faded pixel held at the output.
	logic        v_s1;
	logic [5:0]  row_s1;
	logic        last_s1;
	logic [6:0]  col_s1;
	logic [8:0]  fade_s1;
	logic        out_v_q;
	out_item_t   out_q;
	logic        adv;
	logic        s1_move;
	logic [16:0] r_m;
	logic [16:0] g_m;
	logic [16:0] b_m;

	// A row is only read once the accumulator is below one whole texture row.
	assign s1_move   = !out_v_q || out_ready;
	assign adv       = busy_q && (!v_s1 || s1_move) && (acc_q < {4'd0, den_q});
	assign job_ready = !busy_q;
	assign tex_re    = adv;
	assign tex_raddr = {cur_q.tex, srow_q, cur_q.src_col};
	assign out_item  = out_q;
	assign out_valid = out_v_q;

	// Step the rational row position: acc + step, minus den at most twice while it overflows.
	always_comb begin
		acc_next  = acc_q + {14'd0, step_q};
		srow_next = srow_q;
		if (acc_next >= {4'd0, den_q}) begin
			acc_next  = acc_next - {4'd0, den_q};
			srow_next = srow_next + 6'd1;
			if (acc_next >= {4'd0, den_q}) begin
				acc_next  = acc_next - {4'd0, den_q};
				srow_next = srow_next + 6'd1;
			end
		end
	end

	assign r_m = 17'(tex_rdata[23:16]) * 17'(fade_s1);
	assign g_m = 17'(tex_rdata[15:8]) * 17'(fade_s1);
	assign b_m = 17'(tex_rdata[7:0]) * 17'(fade_s1);

	// Control of the row walk and the two output stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			v_s1    <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (!busy_q && job_valid) begin
				busy_q <= 1'b1;
			end else if (adv && idx_q + 7'd1 == cur_q.count) begin
				busy_q <= 1'b0;
			end
			if (s1_move) begin
				v_s1    <= adv;
				out_v_q <= v_s1;
			end else if (adv) begin
				v_s1 <= 1'b1;
			end
		end
	end

	// Datapath. Unclipped rows: 64*i/h, step 64 over den h.
	// Clipped rows: 64*((h-64)+2i)/(2h), step 128 over den 2h, start from h-64.
	always_ff @(posedge clk) begin
		if (!busy_q && job_valid) begin
			cur_q <= job;
			idx_q <= '0;
			if (job.clipped) begin
				den_q  <= {1'b0, job.height, 1'b0};
				step_q <= 8'(2 * TexSize);
				// 64*(h-64) / (2h) = 32 - 2048/h, computed by subtraction below.
				acc_q  <= 22'(({6'd0, job.height} - 22'(ScreenRows)) << 6);
				srow_q <= '0;
			end else begin
				den_q  <= {2'd0, job.height};
				step_q <= 8'(TexSize);
				acc_q  <= '0;
				srow_q <= '0;
			end
		end else if (busy_q && acc_q >= {4'd0, den_q}) begin
			// Normalize the row position, one subtraction a cycle.
			acc_q  <= acc_q - {4'd0, den_q};
			srow_q <= srow_q + 6'd1;
		end else if (adv) begin
			idx_q  <= idx_q + 7'd1;
			acc_q  <= acc_next;
			srow_q <= srow_next;
		end
		if (adv) begin
			row_s1  <= 6'(cur_q.start_row + idx_q[5:0]);
			last_s1 <= (idx_q + 7'd1 == cur_q.count);
			col_s1  <= cur_q.column;
			fade_s1 <= cur_q.fade;
		end
		if (s1_move && v_s1) begin
			out_q.out_column <= col_s1;
			out_q.out_row    <= row_s1;
			out_q.pixel_rgb  <= {r_m[15:8], g_m[15:8], b_m[15:8]};
			out_q.last_pixel <= last_s1;
		end
	end
endmodule

@@ design/wall_column_texture_scaler.sv @@
// Top level of the wall column texture scaler.
// Depends on wcts_pkg, wcts_front, wcts_queue, wcts_back and wcts_ram.
//
//  channel   | handshake              | payload
//  input     | in_valid / in_ready    | in_item (in_item_t)
//  output    | out_valid / out_ready  | out_item (out_item_t)
//  config    | fade_distance_we       | fade_distance_wdata
//
// A texel write waits while an earlier draw is dividing, queued or walking.
// A draw passes through the bit-serial fade division in the front part (skipped at
// distance zero), then the back part reads one visible row at a time (up to 64), with
// extra normalization steps for texture rows skipped beyond two in a step and to place
// the first row of a clipped wall. Reset is asynchronous and needs no clearing pass.
// Either side may stall; the two-entry job queue decouples the parts.
module wall_column_texture_scaler
	import wcts_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      fade_distance_we,
	input  logic [15:0] fade_distance_wdata,
	input  in_item_t  in_item,
	input  logic      in_valid,
	output logic      in_ready,
	output out_item_t out_item,
	output logic      out_valid,
	input  logic      out_ready
);
	logic [15:0] fade_q;
	logic        tex_we;
	logic [14:0] tex_waddr;
	logic [23:0] tex_wdata;
	logic        tex_re;
	logic [14:0] tex_raddr;
	logic [23:0] tex_rdata;
	col_job_t    fq_job;
	logic        fq_valid;
	logic        fq_ready;
	col_job_t    qb_job;
	logic        qb_valid;
	logic        qb_ready;
	logic        draw_pending;

	// A draw is pending while a job waits in the queue or the back part is walking.
	assign draw_pending = qb_valid || !qb_ready;

	// Fade distance register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fade_q <= FadeReset;
		end else if (fade_distance_we) begin
			fade_q <= fade_distance_wdata;
		end
	end

	wcts_front u_front (
		.clk, .arst_n, .fade_distance(fade_q), .draw_pending,
		.in_item, .in_valid, .in_ready,
		.tex_we, .tex_waddr, .tex_wdata,
		.job(fq_job), .job_valid(fq_valid), .job_ready(fq_ready)
	);

	wcts_queue u_queue (
		.clk, .arst_n, .wr_job(fq_job), .wr_valid(fq_valid), .wr_ready(fq_ready),
		.rd_job(qb_job), .rd_valid(qb_valid), .rd_ready(qb_ready)
	);

	wcts_back u_back (
		.clk, .arst_n, .job(qb_job), .job_valid(qb_valid), .job_ready(qb_ready),
		.tex_re, .tex_raddr, .tex_rdata, .out_item, .out_valid, .out_ready
	);

	wcts_ram #(.Width(24), .Depth(StoreDepth)) u_store (
		.clk, .we(tex_we), .waddr(tex_waddr), .wdata(tex_wdata),
		.re(tex_re), .raddr(tex_raddr), .rdata(tex_rdata)
	);
endmodule

@@ test/wcts_column_checker.sv @@
// Checker for the wall column texture scaler: keeps its own texture store and
// fade register, predicts the pixels of each draw and compares them in order.
// Depends on wcts_pkg.
module wcts_column_checker
	import wcts_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      fade_distance_we,
	input  logic [15:0] fade_distance_wdata,
	input  in_item_t  in_item,
	input  logic      in_valid,
	input  logic      in_ready,
	input  out_item_t out_item,
	input  logic      out_valid,
	input  logic      out_ready,
	output int        mismatch_count,
	output int        pending_pixels,
	output int        pixels_seen
);
	timeunit 1ns;
	timeprecision 1ps;

	logic [23:0] texels [0:StoreDepth-1];
	logic [15:0] fade_numer;
	out_item_t   expected_pixels [$];

	// Work out every pixel a draw transaction produces and queue them.
	task automatic predict_column(input in_item_t it);
		longint unsigned h, f, src_row;
		int unsigned fade, tex, src_col, start, count, addr;
		logic [23:0] t;
		out_item_t px;
		h = it.wall_height;
		if (h == 0) return;
		if (it.distance == 0) fade = 256;
		else begin
			f = (longint'(fade_numer) << 8) / it.distance;
			fade = (f > 256) ? 256 : int'(f);
		end
		tex = (it.wall_kind + (it.side_west_east ? TextureCount / 2 : 0)) % TextureCount;
		src_col = (longint'(it.texture_u) * TexSize) >> 16;
		if (h > ScreenRows) begin
			start = 0;
			count = ScreenRows;
		end else begin
			start = (ScreenRows - h) / 2;
			count = h;
		end
		for (int i = 0; i < count; i++) begin
			if (h > ScreenRows)
				src_row = (TexSize * ((h - ScreenRows) + 2 * i)) / (2 * h);
			else
				src_row = (TexSize * i) / h;
			addr = (tex * TexSize * TexSize + src_row * TexSize + src_col) & (StoreDepth - 1);
			t = texels[addr];
			px.out_column = it.column_x;
			px.out_row = 6'(start + i);
			px.pixel_rgb = {8'((t[23:16] * fade) >> 8), 8'((t[15:8] * fade) >> 8),
				8'((t[7:0] * fade) >> 8)};
			px.last_pixel = (i + 1 == count);
			expected_pixels.push_back(px);
		end
	endtask

	// Output side is compared before new input is predicted on the same edge.
	always @(posedge clk or negedge arst_n) begin
		out_item_t exp_px;
		if (!arst_n) begin
			fade_numer = FadeReset;
			mismatch_count = 0;
			pixels_seen = 0;
			expected_pixels.delete();
		end else begin
			if (fade_distance_we) fade_numer = fade_distance_wdata;
			if (out_valid && out_ready) begin
				pixels_seen++;
				if (expected_pixels.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("ERROR: unexpected pixel %p", out_item);
				end else begin
					exp_px = expected_pixels.pop_front();
					if (exp_px !== out_item) begin
						mismatch_count++;
						if (mismatch_count <= 10)
							$display("ERROR: pixel mismatch, expected %p, got %p",
								exp_px, out_item);
					end
				end
			end
			if (in_valid && in_ready) begin
				if (in_item.func == FUNC_WRITE) texels[in_item.texel_index] = in_item.texel_rgb;
				else predict_column(in_item);
			end
		end
		pending_pixels = expected_pixels.size();
	end

endmodule

@@ test/tb.sv @@
// Testbench top for the wall column texture scaler: drives texel loads and draw
// transactions under several flow settings and fade values, and reports the verdict.
// Depends on wcts_pkg, wall_column_texture_scaler and wcts_column_checker.
module tb;
	import wcts_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	// One texture column is loaded: every row for the full texture, a few rows elsewhere.
	localparam int unsigned LoadedCol = 63;
	localparam int unsigned FullTex   = 6;
	localparam logic [1:0]  FullKind  = 2'd2;
	localparam logic        FullSide  = 1'b1;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        fade_distance_we = 0;
	logic [15:0] fade_distance_wdata = '0;
	in_item_t    in_item = '0;
	logic        in_valid = 0;
	logic        in_ready;
	out_item_t   out_item;
	logic        out_valid;
	logic        out_ready = 0;
	int          mismatch_count, pending_pixels, pixels_seen;
	int          send_idle_pct = 0, stall_pct = 0;
	int          draws_sent = 0, loads_sent = 0;

	// Rows loaded in the other textures; heights 1, 2 and 4 read only these.
	int unsigned sparse_rows [4] = '{0, 16, 32, 48};

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	wall_column_texture_scaler DUT (
		.clk, .arst_n, .fade_distance_we, .fade_distance_wdata,
		.in_item, .in_valid, .in_ready, .out_item, .out_valid, .out_ready
	);

	wcts_column_checker checker_i (
		.clk, .arst_n, .fade_distance_we, .fade_distance_wdata,
		.in_item, .in_valid, .in_ready, .out_item, .out_valid, .out_ready,
		.mismatch_count, .pending_pixels, .pixels_seen
	);

	// Receiver back-pressure.
	always @(posedge clk) out_ready <= ($urandom_range(0, 99) >= stall_pct);

	// Present one transaction; valid stays high after acceptance until the next call.
	task automatic send(input in_item_t it);
		if ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 0;
			@(posedge clk);
			while ($urandom_range(0, 99) < send_idle_pct) @(posedge clk);
		end
		in_item <= it;
		in_valid <= 1;
		forever begin
			@(negedge clk);
			if (in_ready) break;
			@(posedge clk);
		end
		@(posedge clk);
		if (it.func == FUNC_DRAW) draws_sent++;
		else loads_sent++;
	endtask

	task automatic load_texel(input int unsigned addr, input logic [23:0] rgb);
		in_item_t it;
		it = in_item_t'({$urandom, $urandom, $urandom});
		it.func = FUNC_WRITE;
		it.texel_index = 15'(addr);
		it.texel_rgb = rgb;
		send(it);
	endtask

	// A draw whose texture column is the loaded one.
	task automatic draw(input logic [15:0] h, input logic [15:0] wall_dist,
			input logic [1:0] kind, input logic side, input logic [6:0] column);
		in_item_t it;
		it = in_item_t'({$urandom, $urandom, $urandom});
		it.func = FUNC_DRAW;
		it.wall_height = h;
		it.distance = wall_dist;
		it.wall_kind = kind;
		it.side_west_east = side;
		it.column_x = column;
		it.texture_u = {6'(LoadedCol), 10'($urandom)};
		send(it);
	endtask

	// Let the block drain completely before a register write.
	task automatic set_fade(input logic [15:0] value);
		in_valid <= 0;
		@(posedge clk);
		while (pending_pixels != 0) @(posedge clk);
		repeat (80) @(posedge clk);
		fade_distance_we <= 1;
		fade_distance_wdata <= value;
		@(posedge clk);
		fade_distance_we <= 0;
	endtask

	task automatic random_phase(input int n);
		logic [15:0] h, wall_dist;
		logic [1:0]  kind;
		logic        side;
		for (int k = 0; k < n; k++) begin
			if ($urandom_range(0, 99) < 25) begin
				load_texel($urandom_range(0, StoreDepth - 1), 24'($urandom));
			end else begin
				wall_dist = ($urandom_range(0, 2) == 0) ? 16'($urandom_range(0, 4096))
					: 16'($urandom);
				if ($urandom_range(0, 1) == 0) begin
					// Any height on the fully loaded texture.
					case ($urandom_range(0, 9))
						0:       h = 16'($urandom);
						1, 2:    h = 16'($urandom_range(65, 300));
						default: h = 16'($urandom_range(0, 64));
					endcase
					kind = FullKind;
					side = FullSide;
				end else begin
					// Any texture with a height that reads only the sparse rows.
					case ($urandom_range(0, 3))
						0:       h = 16'd0;
						1:       h = 16'd1;
						2:       h = 16'd2;
						default: h = 16'd4;
					endcase
					kind = 2'($urandom);
					side = 1'($urandom);
				end
				draw(h, wall_dist, kind, side, 7'($urandom));
			end
		end
	endtask

	initial begin
		logic [15:0] fades [4] = '{16'd2048, 16'd1, 16'd65535, 16'd0};
		int idles [4] = '{0, 69, 0, 36};
		int stalls [4] = '{0, 0, 69, 36};
		repeat (7) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Fill the rows that draws can reach so no draw reads an empty entry.
		for (int r = 0; r < TexSize; r++)
			load_texel(FullTex * TexSize * TexSize + r * TexSize + LoadedCol,
				24'($urandom));
		for (int t = 0; t < TextureCount; t++)
			if (t != FullTex)
				foreach (sparse_rows[s])
					load_texel(t * TexSize * TexSize + sparse_rows[s] * TexSize
						+ LoadedCol, 24'($urandom));
		load_texel(StoreDepth - 1, 24'hFFFFFF);

		set_fade(fades[0]);
		// Directed: zero, tiny, exact-fit, just-clipped and huge heights; zero and far
		// distance; all kinds on both faces; edge columns.
		draw(16'd0, 16'd256, 2'd0, 1'b0, 7'd0);
		draw(16'd1, 16'd0, 2'd0, 1'b0, 7'd0);
		draw(16'd2, 16'd65535, 2'd1, 1'b1, 7'd127);
		draw(16'd63, 16'd1, FullKind, FullSide, 7'd5);
		draw(16'd64, 16'd2048, FullKind, FullSide, 7'd64);
		draw(16'd65, 16'd2049, FullKind, FullSide, 7'd1);
		draw(16'd65535, 16'd4096, FullKind, FullSide, 7'd126);
		draw(16'd128, 16'd512, FullKind, FullSide, 7'd33);
		draw(16'd7, 16'd100, FullKind, FullSide, 7'd20);
		for (int k = 0; k < 4; k++) draw(16'd4, 16'd1000, 2'(k), 1'b1, 7'(k));
		for (int k = 0; k < 4; k++) draw(16'd4, 16'd100, 2'(k), 1'b0, 7'(k + 8));

		for (int p = 0; p < 4; p++) begin
			if (p > 0) set_fade(fades[p]);
			send_idle_pct = idles[p];
			stall_pct = stalls[p];
			random_phase(7);
			set_fade(16'($urandom_range(1, 65535)));
			random_phase(7);
		end

		in_valid <= 0;
		@(posedge clk);
		while (pending_pixels != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		$display("Covered %0d draws and %0d texel loads, %0d pixels checked,", draws_sent,
			loads_sent, pixels_seen);
		$display("across four flow-control settings and fade values from zero to maximum.");
		if (mismatch_count == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

	// Watchdog.
	initial begin
		#5ms;
		$display("ERROR: timeout");
		$display("CHECKS FAILED");
		$finish;
	end

endmodule

@@ wall_column_texture_scaler.f @@
design/wcts_pkg.sv
design/wcts_ram.sv
design/wcts_front.sv
design/wcts_queue.sv
design/wcts_back.sv
design/wall_column_texture_scaler.sv
test/wcts_column_checker.sv
test/tb.sv
